FILE: rtl/core/sssp_pkg.sv
`default_nettype none
package sssp_pkg;
  localparam int NODES = 64;
  localparam int WEIGHT_BITS = 14;
  localparam int NB = $clog2(NODES);
  localparam int AB = 2 * NB;
  localparam int DB = 20;
  localparam int EB = WEIGHT_BITS + 1;
  localparam logic [DB-1:0] DIST_MAX = {DB{1'b1}};

  localparam logic [1:0] REQ_ADD = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_SOLVE = 2'd2;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [5:0]  node_a;
    logic [5:0]  node_b;
    logic [13:0] weight;
  } req_t;

  typedef struct packed {
    logic [5:0]  node;
    logic [19:0] distance;
    logic [5:0]  predecessor;
    logic        reachable;
    logic        has_predecessor;
    logic        last;
  } res_t;

  // edge store access from the controller
  typedef struct packed {
    logic          we;
    logic [AB-1:0] waddr;
    logic [EB-1:0] wdata;
    logic [AB-1:0] raddr;
  } edge_cmd_t;
endpackage
`default_nettype wire

FILE: rtl/core/sssp_stream_if.sv
`default_nettype none
interface sssp_req_if;
  import sssp_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sssp_res_if;
  import sssp_pkg::*;
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/sssp_edge_ram.sv
`default_nettype none
module sssp_edge_ram (
  input  wire logic                   clk_i,
  input  wire sssp_pkg::edge_cmd_t    cmd_i,
  output logic [sssp_pkg::EB-1:0]     rdata_o
);
  import sssp_pkg::*;
  logic [EB-1:0] mem [NODES*NODES];

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.we) mem[cmd_i.waddr] <= cmd_i.wdata;
    rdata_o <= mem[cmd_i.raddr];
  end
endmodule
`default_nettype wire

FILE: rtl/core/sssp_ctrl.sv
`default_nettype none
module sssp_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  sssp_req_if.sink                 req,
  sssp_res_if.source               res,
  output sssp_pkg::edge_cmd_t      cmd_o,
  input  wire logic [sssp_pkg::EB-1:0] rdata_i,
  output logic                     busy_o
);
  import sssp_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd1, S_ADDR = 4'd2, S_ADDW = 4'd3,
                         S_INIT = 4'd4, S_SCAN = 4'd5, S_SCANL = 4'd6, S_REL = 4'd7,
                         S_RELW = 4'd8, S_OUT = 4'd9, S_OUTW = 4'd10;

  logic [3:0]    st_q, st_d;
  logic [NB:0]   cnt_q, cnt_d;
  req_t          r_q, r_d;
  logic [NB-1:0] u_q, u_d;
  logic          ufound_q, ufound_d;
  logic [DB-1:0] ud_q, ud_d;
  logic [NB:0]   up_q, up_d;
  logic [NB-1:0] rel_i_q, rel_i_d;
  logic          relv_q, relv_d;

  // per-node scratch memories with a registered read
  logic [DB-1:0] dist_mem [NODES];
  logic [NB:0]   pred_mem [NODES];
  logic [1:0]    flag_mem [NODES];
  logic [NODES-1:0] init_q, init_d;
  logic [DB-1:0] dist_rd;
  logic [NB:0]   pred_rd;
  logic [1:0]    flag_rd;
  logic [NB-1:0] sraddr;
  logic          swe;
  logic [NB-1:0] swaddr;
  logic [DB-1:0] swdist;
  logic [NB:0]   swpred;
  logic [1:0]    swflag;
  logic          sclr;

  always_ff @(posedge clk_i) begin
    if (swe) begin
      dist_mem[swaddr] <= swdist;
      pred_mem[swaddr] <= swpred;
      flag_mem[swaddr] <= swflag;
    end
    dist_rd <= dist_mem[sraddr];
    pred_rd <= pred_mem[sraddr];
    flag_rd <= flag_mem[sraddr];
  end

  // reached flag: reset per solve in flip-flops
  logic [1:0] fl_eff;
  assign fl_eff = init_q[rel_i_q] ? flag_rd : 2'b00;

  always_comb begin
    init_d = init_q;
    if (sclr) init_d = '0;
    if (swe) init_d[swaddr] = 1'b1;
  end

  logic [NB-1:0] cidx;
  assign cidx = cnt_q[NB-1:0];
  logic [NB:0] nodes_c;
  assign nodes_c = (NB+1)'(NODES);
  logic [EB-1:0] wnew;
  assign wnew = {1'b1, r_q.weight[WEIGHT_BITS-1:0]};
  logic [DB:0] sum;
  assign sum = {1'b0, ud_q} + (DB+1)'(rdata_i[WEIGHT_BITS-1:0]);
  logic [DB-1:0] nd;
  assign nd = sum[DB] ? DIST_MAX : sum[DB-1:0];

  always_comb begin
    st_d = st_q; cnt_d = cnt_q; r_d = r_q; u_d = u_q; ufound_d = ufound_q;
    ud_d = ud_q; up_d = up_q; rel_i_d = rel_i_q; relv_d = 1'b0;
    cmd_o = '0; swe = 1'b0; swaddr = rel_i_q; swdist = '0; swpred = '0; swflag = '0;
    sraddr = cidx; sclr = 1'b0;
    req.ready = 1'b0; res.valid = 1'b0; res.data = '0;
    case (st_q)
      S_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          r_d = req.data;
          if (req.data.req_type == REQ_SOLVE) begin
            st_d = S_INIT;
          end else if ((req.data.req_type == REQ_ADD || req.data.req_type == REQ_REMOVE)
                       && req.data.node_a != req.data.node_b) begin
            st_d = S_ADDR;
          end
          cmd_o.raddr = {req.data.node_a[NB-1:0], req.data.node_b[NB-1:0]};
        end
      end
      S_ADDR: begin
        // first direction here, the reverse in S_ADDW; an add that is not shorter than a stored edge writes neither
        if (r_q.req_type == REQ_REMOVE) begin
          cmd_o.we = 1'b1; cmd_o.wdata = '0;
          cmd_o.waddr = {r_q.node_a[NB-1:0], r_q.node_b[NB-1:0]};
          st_d = S_ADDW;
        end else if (!(rdata_i[WEIGHT_BITS] &&
                       rdata_i[WEIGHT_BITS-1:0] <= wnew[WEIGHT_BITS-1:0])) begin
          cmd_o.we = 1'b1; cmd_o.wdata = wnew;
          cmd_o.waddr = {r_q.node_a[NB-1:0], r_q.node_b[NB-1:0]};
          st_d = S_ADDW;
        end else st_d = S_IDLE;
      end
      S_ADDW: begin
        cmd_o.we = 1'b1;
        cmd_o.wdata = r_q.req_type == REQ_REMOVE ? '0 : wnew;
        cmd_o.waddr = {r_q.node_b[NB-1:0], r_q.node_a[NB-1:0]};
        st_d = S_IDLE;
      end
      S_INIT: begin
        sclr = 1'b1;
        ufound_d = 1'b0;
        cnt_d = '0;
        if ({1'b0, r_q.node_a} < nodes_c) begin
          swe = 1'b1; swaddr = r_q.node_a[NB-1:0];
          swdist = '0; swpred = '0; swflag = 2'b01;
          st_d = S_SCAN;
        end else st_d = S_OUT;
      end
      S_SCAN: begin
        // read node cidx; result evaluated next cycle
        sraddr = cidx;
        rel_i_d = cidx;
        relv_d = cnt_q < nodes_c;
        cnt_d = cnt_q + 1'b1;
        if (relv_q && fl_eff == 2'b01 && (!ufound_q || dist_rd < ud_q)) begin
          ufound_d = 1'b1; u_d = rel_i_q; ud_d = dist_rd; up_d = pred_rd;
        end
        if (cnt_q == nodes_c) st_d = S_SCANL;
      end
      S_SCANL: begin
        if (!ufound_q) begin
          st_d = S_OUT; cnt_d = '0;
        end else begin
          swe = 1'b1; swaddr = u_q; swdist = ud_q; swpred = up_q;
          swflag = 2'b11;
          sraddr = u_q;
          st_d = S_REL; cnt_d = '0;
        end
      end
      S_REL: begin
        // pipelined: issue edge and scratch reads, finish previous node
        sraddr = cidx;
        cmd_o.raddr = {u_q, cidx};
        rel_i_d = cidx;
        relv_d = cnt_q < nodes_c;
        cnt_d = cnt_q + 1'b1;
        if (relv_q && rdata_i[WEIGHT_BITS] && !fl_eff[1] &&
            (!fl_eff[0] || nd < dist_rd)) begin
          swe = 1'b1; swaddr = rel_i_q; swdist = nd;
          swpred = {1'b1, u_q}; swflag = 2'b01;
        end
        if (cnt_q == nodes_c) begin
          st_d = S_SCAN; cnt_d = '0; ufound_d = 1'b0;
        end
      end
      S_OUT: begin
        sraddr = cidx; rel_i_d = cidx;
        st_d = S_OUTW;
      end
      S_OUTW: begin
        sraddr = cidx; rel_i_d = cidx;
        res.valid = 1'b1;
        res.data.node = 6'(rel_i_q);
        res.data.reachable = fl_eff[0];
        res.data.distance = fl_eff[0] ? dist_rd : '0;
        res.data.has_predecessor = fl_eff[0] & pred_rd[NB];
        res.data.predecessor = (fl_eff[0] & pred_rd[NB]) ? 6'(pred_rd[NB-1:0]) : '0;
        res.data.last = rel_i_q == NB'(NODES-1);
        if (res.ready) begin
          if (rel_i_q == NB'(NODES-1)) st_d = S_IDLE;
          else begin
            cnt_d = cnt_q + 1'b1; st_d = S_OUT;
          end
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  assign busy_o = st_q != S_IDLE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; cnt_q <= '0; relv_q <= 1'b0; ufound_q <= 1'b0; init_q <= '0;
    end else begin
      st_q <= st_d; cnt_q <= cnt_d; relv_q <= relv_d; ufound_q <= ufound_d;
      init_q <= init_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q <= r_d; u_q <= u_d; ud_q <= ud_d; up_q <= up_d; rel_i_q <= rel_i_d;
  end
endmodule
`default_nettype wire

FILE: rtl/core/single_source_shortest_paths_core.sv
`default_nettype none
// Shortest-path engine over a 64-node undirected graph held in a 4096-word edge
// memory. A solve settles one node at a time, each with one scan pass of the
// scratch memory and one relax pass over the edge row, and then streams the
// result words. After reset a clearing pass empties the edge memory before
// the first request is taken.
module single_source_shortest_paths_core (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  sssp_req_if.sink   req,
  sssp_res_if.source res
);
  import sssp_pkg::*;

  edge_cmd_t     cmd, cmd_c;
  logic [EB-1:0] rdata;
  logic          busy;
  logic [AB:0]   clr_q;
  logic          clr_run;
  sssp_req_if    req_g ();

  // clearing pass after reset
  assign clr_run = !clr_q[AB];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) clr_q <= '0;
    else if (clr_run) clr_q <= clr_q + 1'b1;
  end

  assign req_g.valid = req.valid & !clr_run;
  assign req_g.data  = req.data;
  assign req.ready   = req_g.ready & !clr_run;

  always_comb begin
    cmd = cmd_c;
    if (clr_run) begin
      cmd.we = 1'b1; cmd.waddr = clr_q[AB-1:0]; cmd.wdata = '0;
    end
  end

  sssp_ctrl u_ctrl (
    .clk_i, .rst_ni, .req(req_g), .res, .cmd_o(cmd_c), .rdata_i(rdata), .busy_o(busy)
  );
  sssp_edge_ram u_ram (.clk_i, .cmd_i(cmd), .rdata_o(rdata));

`ifndef SYNTHESIS
  a_noacc_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !req.ready) else $error("request taken while busy");
  a_noacc_clr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_run |-> !req.ready) else $error("request taken during clearing");
  a_res_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid |-> busy) else $error("result word while idle");
`endif
endmodule
`default_nettype wire
